[rtl/acc_cpu_pkg.sv]
`default_nettype none

package acc_cpu_pkg;

	// Instruction word layout: opcode in the upper bits, operand below
	localparam int OPC_W   = 4;
	localparam int OPND_W  = 7;
	localparam int INSTR_W = OPC_W + OPND_W;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OPC_W-1:0] OP_ADD    = 4'd2;
	localparam logic [OPC_W-1:0] OP_STORE  = 4'd3;
	localparam logic [OPC_W-1:0] OP_SUB    = 4'd4;
	localparam logic [OPC_W-1:0] OP_INPUT  = 4'd5;
	localparam logic [OPC_W-1:0] OP_OUTPUT = 4'd6;
	localparam logic [OPC_W-1:0] OP_HALT   = 4'd7;
	localparam logic [OPC_W-1:0] OP_JUMP   = 4'd8;
	localparam logic [OPC_W-1:0] OP_SKIPZ  = 4'd9;

	// Commands carried by an input word
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EXEC = 1'b1;

	// Port widths of the external fields
	localparam int PC_PORT_W   = 7;
	localparam int DATA_PORT_W = 32;

	// Control of the shared arithmetic unit
	typedef struct packed {
		logic sub;   // a - b instead of a + b
		logic pass;  // drive b straight through
	} alu_ctl_t;

endpackage

`default_nettype wire

[rtl/acc_cpu_ram.sv]
`default_nettype none

module acc_cpu_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [W-1:0]               wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [W-1:0]               rdata
);

	logic [W-1:0]     mem [DEPTH];
	logic [W-1:0]     rd_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	// Write and registered read of the storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Track written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[rtl/acc_cpu_alu.sv]
`default_nettype none

module acc_cpu_alu #(
	parameter int W = 32
) (
	input  wire acc_cpu_pkg::alu_ctl_t ctl,
	input  wire logic [W-1:0]          a,
	input  wire logic [W-1:0]          b,
	output logic      [W-1:0]          y
);

	logic [W-1:0] b_op;

	// Add, subtract through inverted operand, or pass b
	always_comb begin
		b_op = ctl.sub ? ~b : b;
		if (ctl.pass) begin
			y = b;
		end else begin
			y = a + b_op + W'(ctl.sub);
		end
	end

endmodule

`default_nettype wire

[rtl/accumulator_cpu_core_unit.sv]
// Accumulator core: each input word passes from accept through states FETCH and
// EXEC to the result register (instruction RAM read at the accept edge, then data
// RAM read, then execute); no new word is accepted before the last is registered.
// Input stall stays high until then; a result held by output stall delays execute.
// Reset (arst_n, asynchronous) clears PC, accumulator, halt flag and both RAMs' valid
// bits, so both memories read as zero at once; no clearing pass is needed.
`default_nettype none

module accumulator_cpu_core_unit #(
	parameter int INSTR_DEPTH = 128,
	parameter int DATA_DEPTH  = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic [6:0]         load_index,
	input  wire logic [3:0]         load_opcode,
	input  wire logic [6:0]         load_operand,
	input  wire logic signed [31:0] input_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [6:0]              program_counter_now,
	output logic signed [31:0]      accumulator_now,
	output logic                    output_valid,
	output logic signed [31:0]      output_value,
	output logic                    is_halted,
	output logic [3:0]              opcode_executed
);

	localparam int IA_W = $clog2(INSTR_DEPTH);
	localparam int DA_W = $clog2(DATA_DEPTH);
	localparam int OPC_W  = acc_cpu_pkg::OPC_W;
	localparam int OPND_W = acc_cpu_pkg::OPND_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;

	// Architectural state
	logic [IA_W-1:0]       pc_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  halted_q;

	// Captured input word
	logic                                cmd_q;
	logic [IA_W-1:0]                     lidx_q;
	logic [acc_cpu_pkg::INSTR_W-1:0]     lword_q;
	logic [DATA_WIDTH-1:0]               iv_q;

	// Fetched instruction
	logic [acc_cpu_pkg::INSTR_W-1:0]     ir_q;

	// Result register
	logic                  out_valid_q;
	logic [6:0]            pc_out_q;
	logic [31:0]           acc_out_q;
	logic                  ov_q;
	logic [31:0]           oval_q;
	logic                  halt_out_q;
	logic [OPC_W-1:0]      opc_out_q;

	logic                              accept;
	logic                              commit;
	logic                              exec_en;
	logic [OPC_W-1:0]                  op;
	logic [OPND_W-1:0]                 opnd;
	logic [OPND_W-1:0]                 fetch_opnd;
	logic [acc_cpu_pkg::INSTR_W-1:0]   imem_rd;
	logic [DATA_WIDTH-1:0]             dmem_rd;
	logic [DA_W-1:0]                   dmem_ra;
	logic [DA_W-1:0]                   dmem_wa;
	logic [8:0]                        fetch_da_full;
	logic [8:0]                        exec_da_full;
	logic [12:0]                       lidx_full;
	logic [12:0]                       jump_full;
	logic [12:0]                       pc_ext;
	logic [63:0]                       iv_ext;
	logic [63:0]                       acc_ext;
	logic [IA_W-1:0]                   pc_inc1;
	logic [IA_W-1:0]                   pc_exec;
	logic [IA_W-1:0]                   pc_new;
	logic [DATA_WIDTH-1:0]             acc_new;
	logic                              halted_new;
	logic [DATA_WIDTH-1:0]             alu_b;
	logic [DATA_WIDTH-1:0]             alu_y;
	acc_cpu_pkg::alu_ctl_t             alu_ctl;

	function automatic logic [IA_W-1:0] pc_inc(input logic [IA_W-1:0] p);
		logic [IA_W-1:0] last;
		last = IA_W'(INSTR_DEPTH - 1);
		return (p == last) ? '0 : p + 1'b1;
	endfunction

	// Handshake
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign commit    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign exec_en   = (cmd_q == acc_cpu_pkg::CMD_EXEC) && !halted_q;
	assign op        = ir_q[acc_cpu_pkg::INSTR_W-1 -: OPC_W];
	assign opnd      = ir_q[OPND_W-1:0];
	assign fetch_opnd = imem_rd[OPND_W-1:0];

	// Index folding into the memory depths
	assign lidx_full     = 13'(load_index) % 13'(INSTR_DEPTH);
	assign jump_full     = 13'(opnd) % 13'(INSTR_DEPTH);
	assign fetch_da_full = 9'(fetch_opnd) % 9'(DATA_DEPTH);
	assign exec_da_full  = 9'(opnd) % 9'(DATA_DEPTH);
	assign dmem_wa       = DA_W'(exec_da_full);
	assign dmem_ra       = (state_q == ST_FETCH) ? DA_W'(fetch_da_full) : dmem_wa;
	assign iv_ext        = 64'(input_value);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the input word and the fetched instruction
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			lidx_q  <= IA_W'(lidx_full);
			lword_q <= {load_opcode, load_operand};
			iv_q    <= iv_ext[DATA_WIDTH-1:0];
		end
		if (state_q == ST_FETCH) begin
			ir_q <= imem_rd;
		end
	end

	// Instruction RAM: load words write, fetch reads at the PC
	acc_cpu_ram #(
		.W     (acc_cpu_pkg::INSTR_W),
		.DEPTH (INSTR_DEPTH)
	) u_imem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (commit && (cmd_q == acc_cpu_pkg::CMD_LOAD)),
		.waddr  (lidx_q),
		.wdata  (lword_q),
		.raddr  (pc_q),
		.rdata  (imem_rd)
	);

	// Data RAM: read during fetch, written by store at execute
	acc_cpu_ram #(
		.W     (DATA_WIDTH),
		.DEPTH (DATA_DEPTH)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (commit && exec_en && (op == acc_cpu_pkg::OP_STORE)),
		.waddr  (dmem_wa),
		.wdata  (acc_q),
		.raddr  (dmem_ra),
		.rdata  (dmem_rd)
	);

	// Operand select and control of the shared adder
	always_comb begin
		alu_ctl.pass = (op == acc_cpu_pkg::OP_LOAD) || (op == acc_cpu_pkg::OP_INPUT);
		alu_ctl.sub  = (op == acc_cpu_pkg::OP_SUB);
		alu_b        = (op == acc_cpu_pkg::OP_INPUT) ? iv_q : dmem_rd;
	end

	acc_cpu_alu #(
		.W (DATA_WIDTH)
	) u_alu (
		.ctl (alu_ctl),
		.a   (acc_q),
		.b   (alu_b),
		.y   (alu_y)
	);

	// Next architectural state of an executed instruction
	always_comb begin
		pc_inc1    = pc_inc(pc_q);
		pc_exec    = pc_inc1;
		acc_new    = acc_q;
		halted_new = halted_q;
		case (op) inside
			acc_cpu_pkg::OP_LOAD, acc_cpu_pkg::OP_ADD,
			acc_cpu_pkg::OP_SUB, acc_cpu_pkg::OP_INPUT: begin
				acc_new = alu_y;
			end
			acc_cpu_pkg::OP_HALT: begin
				halted_new = 1'b1;
			end
			acc_cpu_pkg::OP_JUMP: begin
				pc_exec = IA_W'(jump_full);
			end
			acc_cpu_pkg::OP_SKIPZ: begin
				if (acc_q == '0) begin
					pc_exec = pc_inc(pc_inc1);
				end
			end
			default: begin
			end
		endcase
		if (!exec_en) begin
			pc_exec    = pc_q;
			acc_new    = acc_q;
			halted_new = halted_q;
		end
		pc_new  = pc_exec;
		pc_ext  = 13'(pc_new);
		acc_ext = 64'(acc_new);
	end

	// Commit architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			acc_q    <= '0;
			halted_q <= 1'b0;
		end else if (commit) begin
			pc_q     <= pc_new;
			acc_q    <= acc_new;
			halted_q <= halted_new;
		end
	end

	// Result word valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload
	always_ff @(posedge clk) begin
		if (commit) begin
			pc_out_q   <= pc_ext[6:0];
			acc_out_q  <= acc_ext[31:0];
			halt_out_q <= halted_new;
			ov_q       <= exec_en && (op == acc_cpu_pkg::OP_OUTPUT);
			oval_q     <= (exec_en && (op == acc_cpu_pkg::OP_OUTPUT)) ?
				acc_ext[31:0] : '0;
			opc_out_q  <= exec_en ? op : '0;
		end
	end

	assign out_valid           = out_valid_q;
	assign program_counter_now = pc_out_q;
	assign accumulator_now     = $signed(acc_out_q);
	assign output_valid        = ov_q;
	assign output_value        = $signed(oval_q);
	assign is_halted           = halt_out_q;
	assign opcode_executed     = opc_out_q;

endmodule

`default_nettype wire
